// ===== rtl/core/scfl_pkg.sv =====
// shared types, constants, size rounding and microcode program of the size class allocator
`default_nettype none
package scfl_pkg;

    localparam int ADDR_W      = 14;
    localparam int SIZE_W      = 15;
    localparam int LEN_W       = 15;
    localparam int RSIZE_W     = 16;
    localparam int NUM_CLASSES = 5;
    localparam int CLS_W       = 3;
    localparam int STEP_W      = 4;

    localparam logic [RSIZE_W-1:0] CLASS_SIZE [NUM_CLASSES] = '{
        16'd16, 16'd80, 16'd140, 16'd280, 16'd560
    };

    typedef enum logic [1:0] {
        OP_ALLOC   = 2'd0,
        OP_FREE    = 2'd1,
        OP_REALLOC = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_DONE   = 2'd0,
        ST_OOM    = 2'd1,
        ST_WASTED = 2'd2,
        ST_KEPT   = 2'd3
    } status_t;

    // one header word: link to the next free header and the block length
    typedef struct packed {
        logic [ADDR_W-1:0] next;
        logic [LEN_W-1:0]  len;
    } hdr_word_t;

    typedef struct packed {
        logic             hit;
        logic [CLS_W-1:0] idx;
    } cls_match_t;

    typedef logic [STEP_W-1:0] step_t;

    typedef enum logic [3:0] {
        ACT_IDLE,
        ACT_MOD_Q,
        ACT_MOD_P,
        ACT_MOD_R,
        ACT_RD_HDR,
        ACT_FREE,
        ACT_ROUND,
        ACT_ALLOC,
        ACT_POP,
        ACT_DONE
    } act_t;

    typedef enum logic [1:0] {
        BR_NEXT,
        BR_DISPATCH,
        BR_JUMP_IF,
        BR_WAIT_IF
    } br_t;

    typedef struct packed {
        act_t  act;
        br_t   br;
        step_t target;
    } ctrl_t;

    // status from the datapath back to the sequencer
    typedef struct packed {
        logic start;
        op_t  op;
        logic flag;
    } seq_status_t;

    localparam step_t STEP_IDLE   = 4'd0;
    localparam step_t STEP_MOD_Q  = 4'd1;
    localparam step_t STEP_MOD_P  = 4'd2;
    localparam step_t STEP_MOD_R  = 4'd3;
    localparam step_t STEP_RD_HDR = 4'd4;
    localparam step_t STEP_FREE   = 4'd5;
    localparam step_t STEP_ROUND  = 4'd6;
    localparam step_t STEP_ALLOC  = 4'd7;
    localparam step_t STEP_POP    = 4'd8;
    localparam step_t STEP_DONE   = 4'd9;

    function automatic ctrl_t ucode(input step_t step);
        ctrl_t w;
        case (step)
            STEP_IDLE:   w = '{act: ACT_IDLE,   br: BR_DISPATCH, target: STEP_IDLE};
            STEP_MOD_Q:  w = '{act: ACT_MOD_Q,  br: BR_NEXT,     target: STEP_IDLE};
            STEP_MOD_P:  w = '{act: ACT_MOD_P,  br: BR_NEXT,     target: STEP_IDLE};
            STEP_MOD_R:  w = '{act: ACT_MOD_R,  br: BR_NEXT,     target: STEP_IDLE};
            STEP_RD_HDR: w = '{act: ACT_RD_HDR, br: BR_NEXT,     target: STEP_IDLE};
            STEP_FREE:   w = '{act: ACT_FREE,   br: BR_JUMP_IF,  target: STEP_DONE};
            STEP_ROUND:  w = '{act: ACT_ROUND,  br: BR_NEXT,     target: STEP_IDLE};
            STEP_ALLOC:  w = '{act: ACT_ALLOC,  br: BR_JUMP_IF,  target: STEP_DONE};
            STEP_POP:    w = '{act: ACT_POP,    br: BR_NEXT,     target: STEP_IDLE};
            STEP_DONE:   w = '{act: ACT_DONE,   br: BR_WAIT_IF,  target: STEP_IDLE};
            default:     w = '{act: ACT_IDLE,   br: BR_DISPATCH, target: STEP_IDLE};
        endcase
        return w;
    endfunction

    function automatic logic [RSIZE_W-1:0] round_size(input logic [SIZE_W-1:0] size);
        logic [RSIZE_W-1:0] s;
        s = (RSIZE_W'(size) + RSIZE_W'(3)) & ~RSIZE_W'(3);
        for (int c = NUM_CLASSES - 1; c >= 0; c--)
        begin
            if (RSIZE_W'(size) < CLASS_SIZE[c])
            begin
                s = CLASS_SIZE[c];
            end
        end
        return s;
    endfunction

    function automatic cls_match_t class_of(input logic [RSIZE_W-1:0] len);
        cls_match_t m;
        m = '0;
        for (int c = 0; c < NUM_CLASSES; c++)
        begin
            if (len == CLASS_SIZE[c])
            begin
                m.hit = 1'b1;
                m.idx = CLS_W'(c);
            end
        end
        return m;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/scfl_useq.sv =====
// microcode sequencer: step counter, control store and branch logic
`default_nettype none
module scfl_useq (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire scfl_pkg::seq_status_t stat,
    output scfl_pkg::ctrl_t            ctrl
);

    scfl_pkg::step_t step_reg;
    scfl_pkg::step_t step_next;

    assign ctrl = scfl_pkg::ucode(step_reg);

    always_comb
    begin
        step_next = step_reg;
        case (ctrl.br)
            scfl_pkg::BR_NEXT:
            begin
                step_next = step_reg + scfl_pkg::STEP_W'(1);
            end
            scfl_pkg::BR_DISPATCH:
            begin
                if (stat.start)
                begin
                    case (stat.op)
                        scfl_pkg::OP_ALLOC:   step_next = scfl_pkg::STEP_ROUND;
                        scfl_pkg::OP_FREE:    step_next = scfl_pkg::STEP_MOD_Q;
                        scfl_pkg::OP_REALLOC: step_next = scfl_pkg::STEP_MOD_Q;
                        default:              step_next = scfl_pkg::STEP_DONE;
                    endcase
                end
            end
            scfl_pkg::BR_JUMP_IF:
            begin
                step_next = stat.flag ? ctrl.target : step_reg + scfl_pkg::STEP_W'(1);
            end
            scfl_pkg::BR_WAIT_IF:
            begin
                step_next = stat.flag ? ctrl.target : step_reg;
            end
            default:
            begin
                step_next = scfl_pkg::STEP_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= scfl_pkg::STEP_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/size_class_free_list_allocator.sv =====
// Size class free list allocator over a byte pool, one request at a time.
// Input channel (in_valid / in_stall) carries op, request_size and block_address;
// output channel (out_valid / out_stall) carries result_address, status, copy_length.
// Every accepted request gives exactly one result transfer.
// A new request is accepted in the cycle after the previous result is registered.
// In the microcode program the header offset is reduced modulo the pool size
// with a reciprocal multiply over three steps, and the header memory read is
// registered, so one step reads a header and another uses it.
// The result sits in an output register; while the receiver stalls it holds,
// and the next request is worked on up to the point of delivering its result.
// Reset empties all class lists and sets the bump offset to BASE_OFFSET;
// header memory contents are undefined until written and need no clearing.
`default_nettype none
module size_class_free_list_allocator #(
    parameter int POOL_BYTES  = 16384,
    parameter int BASE_OFFSET = 24
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [1:0]                    op,
    input  wire logic [scfl_pkg::SIZE_W-1:0]   request_size,
    input  wire logic [scfl_pkg::ADDR_W-1:0]   block_address,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [scfl_pkg::ADDR_W-1:0]        result_address,
    output logic [1:0]                         status,
    output logic [scfl_pkg::LEN_W-1:0]         copy_length
);

    localparam int HDR_WORDS = POOL_BYTES / 4;
    localparam int IW        = $clog2(HDR_WORDS);
    localparam int PW        = $clog2(POOL_BYTES + 1);
    localparam int HW        = $clog2(POOL_BYTES);
    localparam int XW        = $clog2(16384 + POOL_BYTES);
    localparam int OW        = (PW > scfl_pkg::ADDR_W) ? PW : scfl_pkg::ADDR_W;
    localparam int SW        = ((PW > scfl_pkg::RSIZE_W) ? PW : scfl_pkg::RSIZE_W) + 2;
    localparam longint unsigned RECIP = 64'h1_0000_0000 / POOL_BYTES;
    localparam int RW        = $clog2(RECIP + 1);
    localparam int QW        = XW + RW - 32;
    localparam int MW        = XW + RW;
    localparam int QPW       = QW + PW;
    localparam logic [RW-1:0] RECIP_C = RW'(RECIP);

    // header store, one word per four pool bytes
    scfl_pkg::hdr_word_t mem [HDR_WORDS];
    scfl_pkg::hdr_word_t rdata_reg;

    logic [scfl_pkg::ADDR_W-1:0] head_reg [scfl_pkg::NUM_CLASSES];
    logic [PW-1:0]               bump_reg;
    logic                        out_valid_reg;

    scfl_pkg::op_t               op_reg;
    logic [scfl_pkg::SIZE_W-1:0] size_reg;
    logic [scfl_pkg::ADDR_W-1:0] p_reg;
    logic [QW-1:0]               q_reg;
    logic [QPW-1:0]              qp_reg;
    logic [HW-1:0]               hdr_reg;
    logic [scfl_pkg::RSIZE_W-1:0] s_reg;
    logic [scfl_pkg::CLS_W-1:0]  cls_reg;
    logic                        cls_hit_reg;
    logic [scfl_pkg::ADDR_W-1:0] h_reg;
    logic [scfl_pkg::ADDR_W-1:0] res_addr_reg;
    scfl_pkg::status_t           res_status_reg;
    logic [scfl_pkg::LEN_W-1:0]  res_copy_reg;
    logic [scfl_pkg::ADDR_W-1:0] out_addr_reg;
    scfl_pkg::status_t           out_status_reg;
    logic [scfl_pkg::LEN_W-1:0]  out_copy_reg;

    scfl_pkg::ctrl_t       ctrl;
    scfl_pkg::seq_status_t stat;
    scfl_pkg::act_t        act;

    logic                         start;
    logic [XW-1:0]                x;
    logic [MW-1:0]                prod;
    logic [XW-1:0]                r_raw;
    logic [XW-1:0]                r_fix;
    logic [scfl_pkg::LEN_W-1:0]   rd_len;
    scfl_pkg::cls_match_t         free_cls;
    scfl_pkg::cls_match_t         new_cls;
    logic                         keep;
    logic                         listed;
    logic [scfl_pkg::CLS_W-1:0]   head_idx;
    logic [scfl_pkg::ADDR_W-1:0]  head_sel;
    logic                         pop;
    logic [SW-1:0]                bump_sum;
    logic                         oom;
    logic                         out_free;
    logic                         mem_we;
    logic [IW-1:0]                mem_waddr;
    scfl_pkg::hdr_word_t          mem_wdata;
    logic                         mem_re;
    logic [IW-1:0]                mem_raddr;
    logic                         head_we;
    logic [scfl_pkg::CLS_W-1:0]   head_widx;
    logic [scfl_pkg::ADDR_W-1:0]  head_wdata;

    function automatic logic [IW-1:0] word_idx(input logic [OW-1:0] off);
        logic [OW-3:0] w;
        w = off[OW-1:2];
        if (w >= (OW-2)'(HDR_WORDS))
        begin
            return '0;
        end
        return w[IW-1:0];
    endfunction

    scfl_useq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctrl  (ctrl)
    );

    assign act      = ctrl.act;
    assign in_stall = (act != scfl_pkg::ACT_IDLE);
    assign start    = in_valid && !in_stall;

    // header offset = (address - 4) mod pool size, by reciprocal multiply
    assign x     = XW'(p_reg) + XW'(POOL_BYTES) - XW'(4);
    assign prod  = MW'(x) * MW'(RECIP_C);
    assign r_raw = x - XW'(qp_reg);
    assign r_fix = (r_raw >= XW'(POOL_BYTES)) ? r_raw - XW'(POOL_BYTES) : r_raw;

    assign rd_len   = rdata_reg.len;
    assign free_cls = scfl_pkg::class_of(scfl_pkg::RSIZE_W'(rd_len));
    assign new_cls  = scfl_pkg::class_of(scfl_pkg::round_size(size_reg));
    assign keep     = (op_reg == scfl_pkg::OP_REALLOC) && (rd_len > size_reg);
    assign listed   = !keep && free_cls.hit;

    assign head_idx = (act == scfl_pkg::ACT_FREE) ? free_cls.idx : cls_reg;
    assign head_sel = head_reg[head_idx];
    assign pop      = cls_hit_reg && (head_sel != '0);

    assign bump_sum = SW'(bump_reg) + SW'(s_reg) + SW'(4);
    assign oom      = bump_sum > SW'(POOL_BYTES);
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        stat.start = start;
        stat.op    = scfl_pkg::op_t'(op);
        case (act)
            scfl_pkg::ACT_FREE:  stat.flag = keep || (op_reg == scfl_pkg::OP_FREE);
            scfl_pkg::ACT_ALLOC: stat.flag = !pop;
            scfl_pkg::ACT_DONE:  stat.flag = out_free;
            default:             stat.flag = 1'b0;
        endcase
    end

    always_comb
    begin
        mem_we     = 1'b0;
        mem_waddr  = word_idx(OW'(bump_reg));
        mem_wdata  = '{next: '0, len: scfl_pkg::LEN_W'(s_reg)};
        mem_re     = 1'b0;
        mem_raddr  = word_idx(OW'(hdr_reg));
        head_we    = 1'b0;
        head_widx  = cls_reg;
        head_wdata = rdata_reg.next;
        case (act)
            scfl_pkg::ACT_RD_HDR:
            begin
                mem_re = 1'b1;
            end
            scfl_pkg::ACT_FREE:
            begin
                // push onto the class list: old head becomes the link
                mem_we     = listed;
                mem_waddr  = word_idx(OW'(hdr_reg));
                mem_wdata  = '{next: head_sel, len: rd_len};
                head_we    = listed;
                head_widx  = free_cls.idx;
                head_wdata = scfl_pkg::ADDR_W'(hdr_reg);
            end
            scfl_pkg::ACT_ALLOC:
            begin
                mem_re    = pop;
                mem_raddr = word_idx(OW'(head_sel));
                mem_we    = !pop && !oom;
            end
            scfl_pkg::ACT_POP:
            begin
                head_we = 1'b1;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < scfl_pkg::NUM_CLASSES; c++)
            begin
                head_reg[c] <= '0;
            end
            bump_reg      <= PW'(BASE_OFFSET);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (head_we)
            begin
                head_reg[head_widx] <= head_wdata;
            end
            if (act == scfl_pkg::ACT_ALLOC && !pop && !oom)
            begin
                bump_reg <= PW'(bump_sum);
            end
            if (act == scfl_pkg::ACT_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (act)
            scfl_pkg::ACT_IDLE:
            begin
                if (start)
                begin
                    op_reg         <= scfl_pkg::op_t'(op);
                    size_reg       <= request_size;
                    p_reg          <= block_address;
                    res_addr_reg   <= '0;
                    res_status_reg <= scfl_pkg::ST_DONE;
                    res_copy_reg   <= '0;
                end
            end
            scfl_pkg::ACT_MOD_Q:
            begin
                q_reg <= prod[MW-1:32];
            end
            scfl_pkg::ACT_MOD_P:
            begin
                qp_reg <= QPW'(q_reg) * QPW'(POOL_BYTES);
            end
            scfl_pkg::ACT_MOD_R:
            begin
                hdr_reg <= HW'(r_fix);
            end
            scfl_pkg::ACT_FREE:
            begin
                if (keep)
                begin
                    res_addr_reg   <= p_reg;
                    res_status_reg <= scfl_pkg::ST_KEPT;
                end
                else
                begin
                    res_status_reg <= free_cls.hit ? scfl_pkg::ST_DONE : scfl_pkg::ST_WASTED;
                    res_copy_reg   <= (op_reg == scfl_pkg::OP_REALLOC) ? rd_len : '0;
                end
            end
            scfl_pkg::ACT_ROUND:
            begin
                s_reg       <= scfl_pkg::round_size(size_reg);
                cls_reg     <= new_cls.idx;
                cls_hit_reg <= new_cls.hit;
            end
            scfl_pkg::ACT_ALLOC:
            begin
                h_reg <= head_sel;
                if (!pop)
                begin
                    if (oom)
                    begin
                        res_addr_reg   <= '0;
                        res_status_reg <= scfl_pkg::ST_OOM;
                        res_copy_reg   <= '0;
                    end
                    else
                    begin
                        res_addr_reg <= scfl_pkg::ADDR_W'(SW'(bump_reg) + SW'(4));
                    end
                end
            end
            scfl_pkg::ACT_POP:
            begin
                res_addr_reg <= h_reg + scfl_pkg::ADDR_W'(4);
            end
            scfl_pkg::ACT_DONE:
            begin
                if (out_free)
                begin
                    out_addr_reg   <= res_addr_reg;
                    out_status_reg <= res_status_reg;
                    out_copy_reg   <= res_copy_reg;
                end
            end
            default:
            begin
                q_reg <= q_reg;
            end
        endcase
    end

    assign out_valid      = out_valid_reg;
    assign result_address = out_addr_reg;
    assign status         = out_status_reg;
    assign copy_length    = out_copy_reg;

endmodule
`default_nettype wire

// ===== tb/size_class_free_list_allocator_test.sv =====
// self-checking testbench for the size class free list allocator
`timescale 1ns / 1ps
`default_nettype none
module size_class_free_list_allocator_test;

    localparam int POOL_BYTES   = 16384;
    localparam int BASE_OFFSET  = 24;
    localparam int HEADER_WORDS = POOL_BYTES / 4;
    localparam int RANDOM_ITEMS = 350;
    localparam int IDLE_LIMIT   = 2000;
    localparam int SETTLE       = 20;
    localparam int NUM_DIRECTED = 25;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int CLASS_BYTES [scfl_pkg::NUM_CLASSES] = '{16, 80, 140, 280, 560};

    typedef struct packed {
        logic [scfl_pkg::ADDR_W-1:0] addr;
        scfl_pkg::status_t           st;
        logic [scfl_pkg::LEN_W-1:0]  copy;
    } result_t;

    typedef struct packed {
        logic [1:0]                  code;
        logic [scfl_pkg::SIZE_W-1:0] size;
        logic [scfl_pkg::ADDR_W-1:0] addr;
        bit                          typed;
        result_t                     want;
    } directed_row_t;

    // pool laid out by hand: headers at 24, 44, 64, 148, 232, 376, 520, 804, 1368
    localparam directed_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
        '{scfl_pkg::OP_ALLOC,   15'd0,     14'd0,     1'b1, '{14'd28, scfl_pkg::ST_DONE,   15'd0}},
        '{scfl_pkg::OP_ALLOC,   15'd32767, 14'd0,     1'b1, '{14'd0,  scfl_pkg::ST_OOM,    15'd0}},
        '{scfl_pkg::OP_ALLOC,   15'd15,    14'd0,     1'b1, '{14'd48, scfl_pkg::ST_DONE,   15'd0}},
        '{scfl_pkg::OP_ALLOC,   15'd16,    14'd0,     1'b0, '{14'd0,  scfl_pkg::ST_DONE,   15'd0}},
        '{scfl_pkg::OP_ALLOC,   15'd79,    14'd0,     1'b0, '{14'd0,  scfl_pkg::ST_DONE,   15'd0}},
        '{scfl_pkg::OP_ALLOC,   15'd80,    14'd0,     1'b0, '{14'd0,  scfl_pkg::ST_DONE,   15'd0}},
        '{scfl_pkg::OP_ALLOC,   15'd139,   14'd0,     1'b0, '{14'd0,  scfl_pkg::ST_DONE,   15'd0}},
        '{scfl_pkg::OP_ALLOC,   15'd140,   14'd0,     1'b0, '{14'd0,  scfl_pkg::ST_DONE,   15'd0}},
        '{scfl_pkg::OP_ALLOC,   15'd280,   14'd0,     1'b0, '{14'd0,  scfl_pkg::ST_DONE,   15'd0}},
        '{scfl_pkg::OP_ALLOC,   15'd561,   14'd0,     1'b0, '{14'd0,  scfl_pkg::ST_DONE,   15'd0}},
        '{scfl_pkg::OP_FREE,    15'd0,     14'd28,    1'b1, '{14'd0,  scfl_pkg::ST_DONE,   15'd0}},
        '{scfl_pkg::OP_FREE,    15'd0,     14'd1372,  1'b1, '{14'd0,  scfl_pkg::ST_WASTED, 15'd0}},
        '{scfl_pkg::OP_ALLOC,   15'd1,     14'd0,     1'b1, '{14'd28, scfl_pkg::ST_DONE,   15'd0}},
        // unaligned address, header offset is listed as is
        '{scfl_pkg::OP_FREE,    15'd0,     14'd49,    1'b0, '{14'd0,  scfl_pkg::ST_DONE,   15'd0}},
        '{scfl_pkg::OP_ALLOC,   15'd0,     14'd0,     1'b0, '{14'd0,  scfl_pkg::ST_DONE,   15'd0}},
        // freed twice: the 560 list becomes a loop
        '{scfl_pkg::OP_FREE,    15'd0,     14'd808,   1'b0, '{14'd0,  scfl_pkg::ST_DONE,   15'd0}},
        '{scfl_pkg::OP_FREE,    15'd0,     14'd808,   1'b0, '{14'd0,  scfl_pkg::ST_DONE,   15'd0}},
        '{scfl_pkg::OP_ALLOC,   15'd559,   14'd0,     1'b0, '{14'd0,  scfl_pkg::ST_DONE,   15'd0}},
        '{scfl_pkg::OP_ALLOC,   15'd560,   14'd0,     1'b0, '{14'd0,  scfl_pkg::ST_DONE,   15'd0}},
        '{scfl_pkg::OP_REALLOC, 15'd10,    14'd68,    1'b1, '{14'd68, scfl_pkg::ST_KEPT,   15'd0}},
        '{scfl_pkg::OP_REALLOC, 15'd80,    14'd68,    1'b0, '{14'd0,  scfl_pkg::ST_DONE,   15'd0}},
        '{scfl_pkg::OP_REALLOC, 15'd2000,  14'd1372,  1'b0, '{14'd0,  scfl_pkg::ST_DONE,   15'd0}},
        '{scfl_pkg::OP_REALLOC, 15'd20000, 14'd524,   1'b1, '{14'd0,  scfl_pkg::ST_OOM,    15'd0}},
        '{OP_UNUSED,            15'd32767, 14'd16383, 1'b1, '{14'd0,  scfl_pkg::ST_DONE,   15'd0}},
        '{scfl_pkg::OP_ALLOC,   15'd79,    14'd0,     1'b0, '{14'd0,  scfl_pkg::ST_DONE,   15'd0}}
    };

    logic                          clk           = 1'b0;
    logic                          rst_n         = 1'b0;
    logic                          in_valid      = 1'b0;
    logic                          in_stall;
    logic [1:0]                    op            = 2'd0;
    logic [scfl_pkg::SIZE_W-1:0]   request_size  = '0;
    logic [scfl_pkg::ADDR_W-1:0]   block_address = '0;
    logic                          out_valid;
    logic                          out_stall     = 1'b0;
    logic [scfl_pkg::ADDR_W-1:0]   result_address;
    logic [1:0]                    status;
    logic [scfl_pkg::LEN_W-1:0]    copy_length;

    // allocator image kept by the testbench
    scfl_pkg::hdr_word_t           header_words [HEADER_WORDS];
    logic [scfl_pkg::ADDR_W-1:0]   class_heads [scfl_pkg::NUM_CLASSES] = '{default: '0};
    logic [scfl_pkg::LEN_W-1:0]    bump_offset = scfl_pkg::LEN_W'(BASE_OFFSET);
    int                            placed_headers [$];
    logic [scfl_pkg::ADDR_W-1:0]   live_blocks [$];

    result_t                       awaited_results [$];
    int                            fail_count  = 0;
    int                            idle_cycles = 0;
    int                            stall_left  = 0;
    bit                            calm        = 1'b0;

    size_class_free_list_allocator #(
        .POOL_BYTES  (POOL_BYTES),
        .BASE_OFFSET (BASE_OFFSET)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .op             (op),
        .request_size   (request_size),
        .block_address  (block_address),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .result_address (result_address),
        .status         (status),
        .copy_length    (copy_length)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int rounded_length(input logic [scfl_pkg::SIZE_W-1:0] sz);
        for (int c = 0; c < scfl_pkg::NUM_CLASSES; c++)
        begin
            if (int'(sz) < CLASS_BYTES[c])
                return CLASS_BYTES[c];
        end
        return (int'(sz) + 3) & ~3;
    endfunction

    function automatic int class_index(input int len);
        for (int c = 0; c < scfl_pkg::NUM_CLASSES; c++)
        begin
            if (len == CLASS_BYTES[c])
                return c;
        end
        return -1;
    endfunction

    // pop the class list, else carve from the bump region
    function automatic bit take_block(input logic [scfl_pkg::SIZE_W-1:0] sz,
                                      output logic [scfl_pkg::ADDR_W-1:0] granted);
        int len;
        int cls;
        logic [scfl_pkg::ADDR_W-1:0] h;
        len = rounded_length(sz);
        cls = class_index(len);
        granted = '0;
        if (cls >= 0 && class_heads[cls] != '0)
        begin
            h = class_heads[cls];
            class_heads[cls] = header_words[h[scfl_pkg::ADDR_W-1:2]].next;
            granted = h + scfl_pkg::ADDR_W'(4);
            return 1'b1;
        end
        if (int'(bump_offset) + 4 + len > POOL_BYTES)
            return 1'b0;
        header_words[bump_offset[scfl_pkg::ADDR_W-1:2]].len  = scfl_pkg::LEN_W'(len);
        header_words[bump_offset[scfl_pkg::ADDR_W-1:2]].next = '0;
        placed_headers.push_back(int'(bump_offset));
        granted = scfl_pkg::ADDR_W'(int'(bump_offset) + 4);
        bump_offset = scfl_pkg::LEN_W'(int'(bump_offset) + len + 4);
        return 1'b1;
    endfunction

    function automatic bit give_back(input logic [scfl_pkg::ADDR_W-1:0] h);
        int cls;
        cls = class_index(int'(header_words[h[scfl_pkg::ADDR_W-1:2]].len));
        if (cls < 0)
            return 1'b0;
        header_words[h[scfl_pkg::ADDR_W-1:2]].next = class_heads[cls];
        class_heads[cls] = h;
        return 1'b1;
    endfunction

    function automatic result_t predict_request(input logic [1:0] code,
                                                input logic [scfl_pkg::SIZE_W-1:0] sz,
                                                input logic [scfl_pkg::ADDR_W-1:0] addr);
        result_t r;
        logic [scfl_pkg::ADDR_W-1:0] h;
        logic [scfl_pkg::LEN_W-1:0] old_len;
        bit listed;
        r.addr = '0;
        r.st   = scfl_pkg::ST_DONE;
        r.copy = '0;
        h = addr - scfl_pkg::ADDR_W'(4);
        case (code)
            scfl_pkg::OP_ALLOC:
            begin
                if (!take_block(sz, r.addr))
                    r.st = scfl_pkg::ST_OOM;
            end
            scfl_pkg::OP_FREE:
            begin
                if (!give_back(h))
                    r.st = scfl_pkg::ST_WASTED;
            end
            scfl_pkg::OP_REALLOC:
            begin
                old_len = header_words[h[scfl_pkg::ADDR_W-1:2]].len;
                if (old_len > sz)
                begin
                    r.addr = addr;
                    r.st   = scfl_pkg::ST_KEPT;
                end
                else
                begin
                    listed = give_back(h);
                    if (!take_block(sz, r.addr))
                    begin
                        r.st   = scfl_pkg::ST_OOM;
                        r.addr = '0;
                    end
                    else
                    begin
                        r.st   = listed ? scfl_pkg::ST_DONE : scfl_pkg::ST_WASTED;
                        r.copy = old_len;
                    end
                end
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    function automatic void drop_live(input logic [scfl_pkg::ADDR_W-1:0] addr);
        logic [scfl_pkg::ADDR_W-1:0] word_a;
        logic [scfl_pkg::ADDR_W-1:0] word_b;
        word_a = (addr - scfl_pkg::ADDR_W'(4)) >> 2;
        for (int i = 0; i < live_blocks.size(); i++)
        begin
            word_b = (live_blocks[i] - scfl_pkg::ADDR_W'(4)) >> 2;
            if (word_a == word_b)
            begin
                live_blocks.delete(i);
                return;
            end
        end
    endfunction

    function automatic void track_live(input logic [1:0] code,
                                       input logic [scfl_pkg::ADDR_W-1:0] addr,
                                       input result_t r);
        if (code == scfl_pkg::OP_FREE)
            drop_live(addr);
        else if (code == scfl_pkg::OP_REALLOC && r.st != scfl_pkg::ST_KEPT)
        begin
            drop_live(addr);
            if (r.st != scfl_pkg::ST_OOM)
                live_blocks.push_back(r.addr);
        end
        else if (code == scfl_pkg::OP_ALLOC && r.st == scfl_pkg::ST_DONE)
            live_blocks.push_back(r.addr);
    endfunction

    function automatic logic [scfl_pkg::SIZE_W-1:0] pick_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 88)
            return scfl_pkg::SIZE_W'($urandom_range(0, 600));
        else if (r < 96)
            return scfl_pkg::SIZE_W'($urandom_range(600, 2000));
        return scfl_pkg::SIZE_W'($urandom_range(2000, 32767));
    endfunction

    // any address whose header word is the same as that of the given block
    function automatic logic [scfl_pkg::ADDR_W-1:0] alias_of(
            input logic [scfl_pkg::ADDR_W-1:0] addr);
        logic [scfl_pkg::ADDR_W-1:0] base;
        base = ((addr - scfl_pkg::ADDR_W'(4)) & ~scfl_pkg::ADDR_W'(3)) + scfl_pkg::ADDR_W'(4);
        if ($urandom_range(0, 7) == 0)
            return base + scfl_pkg::ADDR_W'($urandom_range(1, 3));
        return addr;
    endfunction

    task automatic issue_request(input logic [1:0] code,
                                 input logic [scfl_pkg::SIZE_W-1:0] sz,
                                 input logic [scfl_pkg::ADDR_W-1:0] addr, input bit typed,
                                 input result_t typed_want);
        int gap;
        result_t forecast;
        gap = calm ? 0 : idle_length();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        op            <= code;
        request_size  <= sz;
        block_address <= addr;
        do @(posedge clk); while (in_stall);
        forecast = predict_request(code, sz, addr);
        awaited_results.push_back(typed ? typed_want : forecast);
        track_live(code, addr, forecast);
    endtask

    task automatic hold_until_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (awaited_results.size() != 0);
    endtask

    // result checking and receiver stalls
    always @(posedge clk)
    begin : result_side
        result_t want;
        int burst;
        if (rst_n && out_valid && !out_stall)
        begin
            if (awaited_results.size() == 0)
            begin
                $error("unexpected result transfer: result_address %0d status %0d",
                       result_address, status);
                fail_count++;
            end
            else
            begin
                want = awaited_results.pop_front();
                if (result_address !== want.addr)
                begin
                    $error("result_address expected %0d got %0d", want.addr, result_address);
                    fail_count++;
                end
                if (status !== want.st)
                begin
                    $error("status expected %0d got %0d", want.st, status);
                    fail_count++;
                end
                if (copy_length !== want.copy)
                begin
                    $error("copy_length expected %0d got %0d", want.copy, copy_length);
                    fail_count++;
                end
            end
        end
        if (calm)
            out_stall <= 1'b0;
        else if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else
        begin
            burst = idle_length();
            out_stall <= (burst > 0);
            stall_left = (burst > 0) ? burst - 1 : 0;
        end
    end

    // cycles with no transfer on either channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
            begin
                idle_cycles++;
                if (idle_cycles >= IDLE_LIMIT)
                begin
                    $display("FAIL");
                    $finish;
                end
            end
        end
    end

    initial
    begin
        int counted;
        int next_drain;
        int choice;
        int room;
        int pick;
        result_t blank;
        logic [1:0] code;
        logic [scfl_pkg::SIZE_W-1:0] sz;
        logic [scfl_pkg::ADDR_W-1:0] addr;
        logic [scfl_pkg::LEN_W-1:0] held_len;

        blank.addr = '0;
        blank.st   = scfl_pkg::ST_DONE;
        blank.copy = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED_ROWS[i])
            issue_request(DIRECTED_ROWS[i].code, DIRECTED_ROWS[i].size, DIRECTED_ROWS[i].addr,
                          DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);

        counted    = 0;
        next_drain = 60;
        while (counted < RANDOM_ITEMS)
        begin
            calm = (counted >= 150 && counted < 200);
            if (counted == next_drain)
            begin
                hold_until_drained();
                next_drain += 130;
            end
            choice = $urandom_range(0, 99);
            addr   = '0;
            sz     = pick_size();
            if (choice >= 94)
            begin
                // ignored opcode, not counted
                issue_request(OP_UNUSED, scfl_pkg::SIZE_W'($urandom_range(0, 32767)),
                              scfl_pkg::ADDR_W'($urandom_range(0, 16383)), 1'b1, blank);
            end
            else
            begin
                if (choice >= 90 && placed_headers.size() > 0)
                begin
                    // any header ever placed, freed or not
                    pick = placed_headers[$urandom_range(0, placed_headers.size() - 1)];
                    addr = scfl_pkg::ADDR_W'(pick + 4 + $urandom_range(0, 3));
                    code = $urandom_range(0, 1) ? scfl_pkg::OP_FREE : scfl_pkg::OP_REALLOC;
                end
                else if (choice >= 42 && live_blocks.size() > 0)
                begin
                    addr = alias_of(live_blocks[$urandom_range(0, live_blocks.size() - 1)]);
                    code = (choice < 67) ? scfl_pkg::OP_FREE : scfl_pkg::OP_REALLOC;
                    if (code == scfl_pkg::OP_REALLOC && $urandom_range(0, 2) == 0)
                    begin
                        // right at the keep-in-place boundary
                        held_len = header_words[(addr - scfl_pkg::ADDR_W'(4)) >> 2].len;
                        sz = scfl_pkg::SIZE_W'(int'(held_len) - $urandom_range(0, 1));
                    end
                end
                else
                begin
                    code = scfl_pkg::OP_ALLOC;
                    room = POOL_BYTES - int'(bump_offset) - 4;
                    if (room >= 560 && $urandom_range(0, 29) == 0)
                        sz = scfl_pkg::SIZE_W'(room + $urandom_range(0, 1));
                end
                issue_request(code, sz, addr, 1'b0, blank);
                counted++;
            end
        end
        calm = 1'b0;
        in_valid <= 1'b0;

        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
`default_nettype wire
